// ===== sv/gbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbm_pkg: shared types and constants
// Field widths, register codes and divider status for the block mean design.
// ----------------------------------------------------------------------------
package gbm_pkg;

    // configuration register widths and reset values
    localparam int REG_DIM_W      = 13;
    localparam int REG_COLS_W     = 5;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_ADDR_W     = 4;
    localparam logic [REG_DIM_W-1:0]  RST_IMG_WIDTH  = 13'd640;
    localparam logic [REG_DIM_W-1:0]  RST_IMG_HEIGHT = 13'd480;
    localparam logic [REG_COLS_W-1:0] RST_GRID_COLS  = 5'd16;
    localparam logic [REG_DIM_W-1:0]  RST_GRID_ROWS  = 13'd16;

    // stream field widths
    localparam int PIX_W   = 8;
    localparam int MEAN_W  = 16;
    localparam int BCOL_W  = 4;
    localparam int BROW_W  = 12;
    localparam int OUT_W   = MEAN_W + BCOL_W + BROW_W;
    localparam int OUSER_W = 2;

    // block sum and divider shape
    localparam int SUM_W  = 32;
    localparam int FRAC_W = 8;
    localparam int DEND_W = SUM_W + FRAC_W;
    localparam int Q_W    = 16;

    // register index, word address bits [3:2]
    typedef enum logic [1:0] {
        REG_IMG_WIDTH  = 2'd0,
        REG_IMG_HEIGHT = 2'd1,
        REG_GRID_COLS  = 2'd2,
        REG_GRID_ROWS  = 2'd3
    } t_reg_idx;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== sv/grid_block_mean.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_block_mean: block-average downsampler
// Sums grey pixels per grid block and gives each block's mean in 8.8 format.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order (tdata: pixel, tuser:
// frame start). Block means leave on m_axis in raster order of blocks
// (tdata: mean, block_col, block_row; tuser: all_cols, all_rows; tlast marks
// the last block of the frame). Image and grid sizes sit in an APB register
// bank; a write also restarts the frame.
// An ordinary pixel is accepted, then the block sum held in a small ram is
// read, updated and written back. The bottom-right pixel of a block also
// sends the mean through the shared 16-step divider, and the result is
// registered on m_axis. After reset and after every register write the
// same divider works out the nominal and last block lengths of both axes,
// while s_axis_tready stays low.
// A result waits in the output register while m_axis_tready is low; further
// pixels are still taken until the next block finishes, which then waits for
// the output register to empty.
// ----------------------------------------------------------------------------
module grid_block_mean
    import gbm_pkg::*;
#(
    parameter int MAX_COLS = 16,
    parameter int MAX_DIM  = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]            s_axis_tuser,   // [0] frame_start
    // block mean stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // [15:0] mean, [19:16] block_col,
                                                  // [31:20] block_row
    output logic [OUSER_W-1:0]    m_axis_tuser,   // [0] all_cols, [1] all_rows
    output logic                  m_axis_tlast,   // frame_done
    // register bank
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int POS_W  = $clog2(MAX_DIM);
    localparam int CI_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int COLS_W = $clog2(MAX_COLS + 1);
    localparam int CNT_W  = 2 * DIM_W;

    typedef enum logic [3:0] {
        S_PREP_W,
        S_WAIT_W,
        S_PREP_H,
        S_WAIT_H,
        S_IDLE,
        S_ACC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_PUSH
    } t_state;

    t_state r_state;

    // register bank
    logic [REG_DIM_W-1:0]  r_img_width;
    logic [REG_DIM_W-1:0]  r_img_height;
    logic [REG_COLS_W-1:0] r_grid_cols;
    logic [REG_DIM_W-1:0]  r_grid_rows;

    // block geometry from the divider
    logic [DIM_W-1:0] r_base_w;
    logic [DIM_W-1:0] r_last_w;
    logic [DIM_W-1:0] r_base_h;
    logic [DIM_W-1:0] r_last_h;

    // raster position
    logic [POS_W-1:0] r_x_pos;
    logic [POS_W-1:0] r_y_pos;
    logic [CI_W-1:0]  r_col_idx;
    logic [POS_W-1:0] r_x_in_blk;
    logic [POS_W-1:0] r_band_idx;
    logic [POS_W-1:0] r_y_in_band;
    logic [MAX_COLS-1:0] r_valid;

    // pixel and finished block
    logic [PIX_W-1:0]  r_pix;
    logic [CNT_W-1:0]  r_cnt;
    logic [DEND_W-1:0] r_dend;
    logic [BCOL_W-1:0] r_res_col;
    logic [BROW_W-1:0] r_res_row;
    logic              r_res_allc;
    logic              r_res_allr;
    logic              r_res_last;

    // output register
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic [OUSER_W-1:0] r_out_user;
    logic              r_out_last;

    // combinational
    logic              cfg_wr;
    t_reg_idx          cfg_idx;
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [COLS_W-1:0] cols_eff;
    logic [DIM_W-1:0]  rows_eff;
    logic              single_c;
    logic              single_r;
    logic [DIM_W-1:0]  bw;
    logic [DIM_W-1:0]  bh;
    logic              row_end;
    logic              frame_end_y;
    logic              end_x;
    logic              end_y;
    logic              corner;
    logic [SUM_W-1:0]  ram_rdata;
    logic [SUM_W-1:0]  acc_sum;
    logic [CNT_W-1:0]  blk_cnt;
    logic              div_start;
    logic [DEND_W-1:0] div_dend;
    logic [CNT_W-1:0]  div_dsr;
    t_div_stat         div_stat;
    logic [Q_W-1:0]    div_quo;
    logic [CNT_W-1:0]  div_rem;
    logic              ram_we;
    logic [CI_W-1:0]   ram_raddr;
    logic              out_load;

    // register access decode
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            REG_IMG_WIDTH:  prdata = CFG_DATA_W'(r_img_width);
            REG_IMG_HEIGHT: prdata = CFG_DATA_W'(r_img_height);
            REG_GRID_COLS:  prdata = CFG_DATA_W'(r_grid_cols);
            REG_GRID_ROWS:  prdata = CFG_DATA_W'(r_grid_rows);
            default:        prdata = '0;
        endcase
    end

    // clamp registers into their working range
    always_comb begin
        if (r_img_width == '0)                 w_eff = DIM_W'(1);
        else if (32'(r_img_width) > MAX_DIM)   w_eff = DIM_W'(MAX_DIM);
        else                                   w_eff = DIM_W'(r_img_width);
        if (r_img_height == '0)                h_eff = DIM_W'(1);
        else if (32'(r_img_height) > MAX_DIM)  h_eff = DIM_W'(MAX_DIM);
        else                                   h_eff = DIM_W'(r_img_height);
        if (r_grid_cols == '0)                 cols_eff = COLS_W'(1);
        else if (32'(r_grid_cols) > MAX_COLS)  cols_eff = COLS_W'(MAX_COLS);
        else                                   cols_eff = COLS_W'(r_grid_cols);
        if (r_grid_rows == '0)                 rows_eff = DIM_W'(1);
        else if (32'(r_grid_rows) > MAX_DIM)   rows_eff = DIM_W'(MAX_DIM);
        else                                   rows_eff = DIM_W'(r_grid_rows);
    end

    // block size and block end for the current pixel
    always_comb begin
        single_c = (32'(w_eff) < 32'(cols_eff));
        single_r = (32'(h_eff) < 32'(rows_eff));
        if (single_c)
            bw = w_eff;
        else if ((COLS_W'(r_col_idx) + COLS_W'(1)) >= cols_eff)
            bw = r_last_w;
        else
            bw = r_base_w;
        if (single_r)
            bh = h_eff;
        else if ((DIM_W'(r_band_idx) + DIM_W'(1)) >= rows_eff)
            bh = r_last_h;
        else
            bh = r_base_h;
        row_end     = (DIM_W'(r_x_pos) + DIM_W'(1)) >= w_eff;
        frame_end_y = (DIM_W'(r_y_pos) + DIM_W'(1)) >= h_eff;
        end_x       = ((DIM_W'(r_x_in_blk) + DIM_W'(1)) >= bw) || row_end;
        end_y       = ((DIM_W'(r_y_in_band) + DIM_W'(1)) >= bh) || frame_end_y;
        corner      = end_x && end_y;
        acc_sum     = (r_valid[r_col_idx] ? ram_rdata : '0) + SUM_W'(r_pix);
        blk_cnt     = CNT_W'(bw) * CNT_W'(bh);
    end

    // block sum store, read issued with the pixel transaction
    assign ram_raddr = s_axis_tuser[0] ? '0 : r_col_idx;
    assign ram_we    = (r_state == S_ACC) && !corner;

    gbm_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_COLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col_idx),
        .i_wdata (acc_sum),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // divider operand select
    always_comb begin
        div_start = (r_state == S_PREP_W) || (r_state == S_PREP_H) ||
                    (r_state == S_DIV_GO);
        case (r_state)
            S_PREP_W: begin
                div_dend = DEND_W'(w_eff);
                div_dsr  = CNT_W'(cols_eff);
            end
            S_PREP_H: begin
                div_dend = DEND_W'(h_eff);
                div_dsr  = CNT_W'(rows_eff);
            end
            default: begin
                div_dend = r_dend;
                div_dsr  = r_cnt;
            end
        endcase
    end

    gbm_div #(
        .DSR_W (CNT_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dend),
        .i_divisor   (div_dsr),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // finished mean moves into the output register
    assign out_load = !cfg_wr && (r_state == S_PUSH) && (!r_out_valid || m_axis_tready);

    // sequencer, position counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_PREP_W;
            r_img_width  <= RST_IMG_WIDTH;
            r_img_height <= RST_IMG_HEIGHT;
            r_grid_cols  <= RST_GRID_COLS;
            r_grid_rows  <= RST_GRID_ROWS;
            r_x_pos      <= '0;
            r_y_pos      <= '0;
            r_col_idx    <= '0;
            r_x_in_blk   <= '0;
            r_band_idx   <= '0;
            r_y_in_band  <= '0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // output transaction loaded or taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_wr) begin
                // register write restarts the frame and the geometry
                case (cfg_idx)
                    REG_IMG_WIDTH:  r_img_width  <= pwdata[REG_DIM_W-1:0];
                    REG_IMG_HEIGHT: r_img_height <= pwdata[REG_DIM_W-1:0];
                    REG_GRID_COLS:  r_grid_cols  <= pwdata[REG_COLS_W-1:0];
                    REG_GRID_ROWS:  r_grid_rows  <= pwdata[REG_DIM_W-1:0];
                    default: ;
                endcase
                r_x_pos     <= '0;
                r_y_pos     <= '0;
                r_col_idx   <= '0;
                r_x_in_blk  <= '0;
                r_band_idx  <= '0;
                r_y_in_band <= '0;
                r_valid     <= '0;
                r_state     <= S_PREP_W;
            end else begin
                case (r_state)
                    S_PREP_W: r_state <= S_WAIT_W;
                    S_WAIT_W: begin
                        if (div_stat.done) begin
                            r_base_w <= DIM_W'(div_quo);
                            r_last_w <= DIM_W'(div_quo) + DIM_W'(div_rem);
                            r_state  <= S_PREP_H;
                        end
                    end
                    S_PREP_H: r_state <= S_WAIT_H;
                    S_WAIT_H: begin
                        if (div_stat.done) begin
                            r_base_h <= DIM_W'(div_quo);
                            r_last_h <= DIM_W'(div_quo) + DIM_W'(div_rem);
                            r_state  <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (s_axis_tvalid) begin
                            r_pix <= s_axis_tdata;
                            if (s_axis_tuser[0]) begin
                                r_x_pos     <= '0;
                                r_y_pos     <= '0;
                                r_col_idx   <= '0;
                                r_x_in_blk  <= '0;
                                r_band_idx  <= '0;
                                r_y_in_band <= '0;
                                r_valid     <= '0;
                            end
                            r_state <= S_ACC;
                        end
                    end
                    S_ACC: begin
                        r_valid[r_col_idx] <= !corner;
                        // advance the raster position
                        if (row_end) begin
                            r_x_pos    <= '0;
                            r_col_idx  <= '0;
                            r_x_in_blk <= '0;
                            if (frame_end_y) begin
                                r_y_pos     <= '0;
                                r_band_idx  <= '0;
                                r_y_in_band <= '0;
                            end else begin
                                r_y_pos <= r_y_pos + POS_W'(1);
                                if (end_y) begin
                                    r_band_idx  <= r_band_idx + POS_W'(1);
                                    r_y_in_band <= '0;
                                end else begin
                                    r_y_in_band <= r_y_in_band + POS_W'(1);
                                end
                            end
                        end else begin
                            r_x_pos <= r_x_pos + POS_W'(1);
                            if (end_x) begin
                                r_col_idx  <= r_col_idx + CI_W'(1);
                                r_x_in_blk <= '0;
                            end else begin
                                r_x_in_blk <= r_x_in_blk + POS_W'(1);
                            end
                        end
                        // block finished: capture its sum and size
                        if (corner) begin
                            r_cnt      <= blk_cnt;
                            r_dend     <= {acc_sum, {FRAC_W{1'b0}}};
                            r_res_col  <= single_c ? '0 : BCOL_W'(r_col_idx);
                            r_res_row  <= single_r ? '0 : BROW_W'(r_band_idx);
                            r_res_allc <= single_c;
                            r_res_allr <= single_r;
                            r_res_last <= row_end && frame_end_y;
                            r_state    <= S_DIV_GO;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_DIV_GO: r_state <= S_DIV_WAIT;
                    S_DIV_WAIT: begin
                        if (div_stat.done) begin
                            r_state <= S_PUSH;
                        end
                    end
                    S_PUSH: begin
                        if (out_load) begin
                            r_out_data  <= {r_res_row, r_res_col, div_quo};
                            r_out_user  <= {r_res_allr, r_res_allc};
                            r_out_last  <= r_res_last;
                            r_state     <= S_IDLE;
                        end
                    end
                    default: r_state <= S_PREP_W;
                endcase
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== sv/gbm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbm_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gbm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbm_div: shared restoring divider
// One quotient bit per cycle; the quotient is known to fit in Q_W bits, so
// the upper dividend bits seed the partial remainder.
// ----------------------------------------------------------------------------
module gbm_div
    import gbm_pkg::*;
#(
    parameter int DSR_W = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DEND_W-1:0] i_dividend,
    input  logic [DSR_W-1:0]  i_divisor,
    output t_div_stat         o_stat,
    output logic [Q_W-1:0]    o_quotient,
    output logic [DSR_W-1:0]  o_remainder
);

    localparam int CW = $clog2(Q_W + 1);

    logic [DSR_W:0]   r_rem;
    logic [Q_W-1:0]   r_quo;
    logic [DSR_W-1:0] r_dsr;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DSR_W:0]   rem_sh;
    logic             q_bit;
    logic [DSR_W:0]   n_rem;

    // one trial subtraction
    always_comb begin
        rem_sh = {r_rem[DSR_W-1:0], r_quo[Q_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dsr});
        n_rem  = q_bit ? (rem_sh - {1'b0, r_dsr}) : rem_sh;
    end

    // operand load and iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_rem  <= (DSR_W + 1)'(i_dividend >> Q_W);
            r_quo  <= i_dividend[Q_W-1:0];
            r_dsr  <= i_divisor;
            r_cnt  <= CW'(Q_W);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[Q_W-2:0], q_bit};
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem[DSR_W-1:0];

endmodule

// ===== sv/gbm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbm_checker: port-level checks for the block mean design
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module gbm_checker
    import gbm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_W-1:0]      m_axis_tdata,
    input logic [OUSER_W-1:0]    m_axis_tuser,
    input logic                  m_axis_tlast
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // geometry is worked out after reset before any pixel is taken
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("pixel taken straight after reset");

    // mean of 8-bit pixels never exceeds 255.0
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[MEAN_W-1:0] <= 16'hFF00))
        else $error("block mean out of range");

    // a block spanning every column reports column zero
    a_allc_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[MEAN_W+BCOL_W-1:MEAN_W] == '0))
        else $error("column index set on full-width block");

    // a block spanning every row reports row zero
    a_allr_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            (m_axis_tdata[OUT_W-1:MEAN_W+BCOL_W] == '0))
        else $error("row index set on full-height block");

endmodule

bind grid_block_mean gbm_checker u_gbm_checker (.*);

// ===== verif/tb_grid_block_mean.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_block_mean: self-checking bench for the block mean downsampler
// Streams grey pixels through small and extreme grids and checks every block
// mean against a cycle-free model of the block sums kept in the bench.
// ----------------------------------------------------------------------------
// Grid sizes are programmed over APB while the block is idle and read back.
// Each accepted pixel transaction updates the bench model, which queues the
// block mean it predicts; every mean transaction is checked field by field
// against the oldest queued one. Both stream sides idle at random, with
// steady stretches, and the sender pauses mid-frame now and then until all
// queued means have come.
// ----------------------------------------------------------------------------
module tb_grid_block_mean;
    import gbm_pkg::*;

    localparam int MAX_COLS      = 16;
    localparam int MAX_DIM       = 4096;
    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_PIXELS = 800;

    // one expected block mean
    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [BCOL_W-1:0] col;
        logic [BROW_W-1:0] row;
        logic              all_c;
        logic              all_r;
        logic              frame_end;
    } t_block_mean;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata  = '0;   // [7:0] pixel
    logic [0:0]            s_axis_tuser  = '0;   // [0] frame_start
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;         // [15:0] mean, [19:16] block_col,
                                                 // [31:20] block_row
    logic [OUSER_W-1:0]    m_axis_tuser;         // [0] all_cols, [1] all_rows
    logic                  m_axis_tlast;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // bench copy of the registers and the block sum state
    logic [REG_DIM_W-1:0]  cfg_width;
    logic [REG_DIM_W-1:0]  cfg_height;
    logic [REG_COLS_W-1:0] cfg_cols;
    logic [REG_DIM_W-1:0]  cfg_rows;
    bit [SUM_W-1:0]        band_sums [MAX_COLS];
    int unsigned           px_x, px_y, blk_col, x_in_blk, band_row, y_in_band;

    t_block_mean           pending_means [$];
    int                    err_count   = 0;
    int                    pixels_sent = 0;
    bit                    tx_steady   = 1'b0;
    bit                    rx_steady   = 1'b0;

    grid_block_mean #(
        .MAX_COLS (MAX_COLS),
        .MAX_DIM  (MAX_DIM)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("tb_grid_block_mean NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        err_count++;
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // block mean model
    // ------------------------------------------------------------------------
    function automatic int unsigned clamp_len(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // nominal block length, the last block takes the remainder
    function automatic int unsigned block_len(input int unsigned len, input int unsigned cnt,
                                              input int unsigned idx);
        int unsigned base;
        if (len < cnt) return len;
        base = len / cnt;
        if (idx + 1 >= cnt) return len - base * (cnt - 1);
        return base;
    endfunction

    function automatic int frame_pixels();
        return clamp_len(cfg_width, MAX_DIM) * clamp_len(cfg_height, MAX_DIM);
    endfunction

    task automatic clear_grid_state();
        foreach (band_sums[i]) band_sums[i] = '0;
        px_x      = 0;
        px_y      = 0;
        blk_col   = 0;
        x_in_blk  = 0;
        band_row  = 0;
        y_in_band = 0;
    endtask

    task automatic reset_grid_model();
        cfg_width  = RST_IMG_WIDTH;
        cfg_height = RST_IMG_HEIGHT;
        cfg_cols   = RST_GRID_COLS;
        cfg_rows   = RST_GRID_ROWS;
        clear_grid_state();
    endtask

    // register write, any write restarts the frame
    task automatic apply_reg(input t_reg_idx idx, input logic [31:0] val);
        case (idx)
            REG_IMG_WIDTH:  cfg_width  = val[REG_DIM_W-1:0];
            REG_IMG_HEIGHT: cfg_height = val[REG_DIM_W-1:0];
            REG_GRID_COLS:  cfg_cols   = val[REG_COLS_W-1:0];
            REG_GRID_ROWS:  cfg_rows   = val[REG_DIM_W-1:0];
            default: ;
        endcase
        clear_grid_state();
    endtask

    // one accepted pixel: add to its block, queue the mean at a block corner
    task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic sof);
        int unsigned       w, h, nc, nr, bw, bh, ci;
        bit                one_c, one_r, end_x, end_y;
        longint unsigned   area, quo;
        t_block_mean       res;
        w  = clamp_len(cfg_width, MAX_DIM);
        h  = clamp_len(cfg_height, MAX_DIM);
        nc = clamp_len(cfg_cols, MAX_COLS);
        nr = clamp_len(cfg_rows, MAX_DIM);
        if (sof) clear_grid_state();
        ci    = (blk_col >= MAX_COLS) ? MAX_COLS - 1 : blk_col;
        one_c = (w < nc);
        one_r = (h < nr);
        bw    = block_len(w, nc, blk_col);
        bh    = block_len(h, nr, band_row);
        band_sums[ci] += pix;
        end_x = (x_in_blk + 1 >= bw) || (px_x + 1 >= w);
        end_y = (y_in_band + 1 >= bh) || (px_y + 1 >= h);

        if (end_x && end_y) begin
            area          = longint'(bw) * longint'(bh);
            quo           = (longint'(band_sums[ci]) << FRAC_W) / area;
            res.mean      = MEAN_W'(quo);
            res.col       = one_c ? '0 : BCOL_W'(blk_col);
            res.row       = one_r ? '0 : BROW_W'(band_row);
            res.all_c     = one_c;
            res.all_r     = one_r;
            res.frame_end = (px_x + 1 >= w) && (px_y + 1 >= h);
            pending_means.push_back(res);
            band_sums[ci] = '0;
        end

        // advance the raster position
        if (px_x + 1 >= w) begin
            px_x     = 0;
            blk_col  = 0;
            x_in_blk = 0;
            if (px_y + 1 >= h) begin
                px_y      = 0;
                band_row  = 0;
                y_in_band = 0;
            end else begin
                px_y++;
                if (end_y) begin
                    band_row++;
                    y_in_band = 0;
                end else begin
                    y_in_band++;
                end
            end
        end else begin
            px_x++;
            if (end_x) begin
                blk_col++;
                x_in_blk = 0;
            end else begin
                x_in_blk++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // mean stream checker and sink stalls
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_block_means
        t_block_mean got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.mean      = m_axis_tdata[MEAN_W-1:0];
            got.col       = m_axis_tdata[MEAN_W+BCOL_W-1:MEAN_W];
            got.row       = m_axis_tdata[OUT_W-1:MEAN_W+BCOL_W];
            got.all_c     = m_axis_tuser[0];
            got.all_r     = m_axis_tuser[1];
            got.frame_end = m_axis_tlast;
            if (pending_means.size() == 0) begin
                report_mismatch("block mean with none queued, mean", got.mean, 0);
            end else begin
                want = pending_means.pop_front();
                if (got.mean !== want.mean) report_mismatch("mean", got.mean, want.mean);
                if (got.col !== want.col) report_mismatch("block_col", got.col, want.col);
                if (got.row !== want.row) report_mismatch("block_row", got.row, want.row);
                if (got.all_c !== want.all_c)
                    report_mismatch("all_cols", got.all_c, want.all_c);
                if (got.all_r !== want.all_r)
                    report_mismatch("all_rows", got.all_r, want.all_r);
                if (got.frame_end !== want.frame_end)
                    report_mismatch("frame_done", got.frame_end, want.frame_end);
            end
        end
    end

    // mostly short idles, a few long ones
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin : sink_stalls
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else if (rx_steady || $urandom_range(0, 99) < 70) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                hold = idle_length() - 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // apb and pixel transactions
    // ------------------------------------------------------------------------
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        // bus goes idle between transfers
        if (psel) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic verify_regs();
        logic [31:0] rd, want;
        t_reg_idx    idx;
        for (int k = 0; k < 4; k++) begin
            idx = t_reg_idx'(k);
            if (psel) @(posedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {idx, 2'b00};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            rd = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            case (idx)
                REG_IMG_WIDTH:  want = 32'(cfg_width);
                REG_IMG_HEIGHT: want = 32'(cfg_height);
                REG_GRID_COLS:  want = 32'(cfg_cols);
                default:        want = 32'(cfg_rows);
            endcase
            if (rd !== want) report_mismatch($sformatf("readback of %s", idx.name()), rd, want);
        end
    endtask

    task automatic program_grid(input logic [31:0] w, input logic [31:0] h,
                                input logic [31:0] nc, input logic [31:0] nr);
        write_reg(REG_IMG_WIDTH, w);
        write_reg(REG_IMG_HEIGHT, h);
        write_reg(REG_GRID_COLS, nc);
        write_reg(REG_GRID_ROWS, nr);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof);
        int gap;
        gap = (!tx_steady && $urandom_range(0, 99) < 35) ? idle_length() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= sof;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pixel(pix, sof);
        pixels_sent++;
    endtask

    // sender stops until every queued mean has come
    task automatic hold_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_means.size() != 0);
    endtask

    // idle block: nothing queued and the divider given time to finish
    task automatic settle_block();
        hold_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return PIX_W'($urandom);
    endfunction

    task automatic send_grid_pixels(input int count, input bit mark_start, input int pause_at);
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) hold_for_results();
            send_pixel(pick_pixel(), mark_start && (k == 0));
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values read back, a partial frame at the default grid gives no mean
    task automatic test_reset_values();
        verify_regs();
        send_grid_pixels(45, 1'b0, -1);
        settle_block();
    endtask

    // 5x3 image on a 2x2 grid: remainder blocks on both axes
    task automatic test_small_grid();
        logic [PIX_W-1:0] pat [15] = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                       8'd0,   8'd1,   8'd128, 8'd254, 8'd255,
                                       8'd0,   8'd0,   8'd0,   8'd0,   8'd7};
        program_grid(32'd5, 32'd3, 32'd2, 32'd2);
        foreach (pat[i]) send_pixel(pat[i], i == 0);
        // wrap into the next frame without a start marker, then restart it
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd10, 1'b1);
        send_grid_pixels(4, 1'b0, -1);
        settle_block();
    endtask

    // axes shorter than their block counts collapse to one block
    task automatic test_whole_axis_blocks();
        program_grid(32'd3, 32'd2, 32'd16, 32'd5);
        send_grid_pixels(6, 1'b1, -1);
        send_grid_pixels(6, 1'b0, -1);
        settle_block();
        program_grid(32'd2, 32'd2, 32'd1, 32'd3);
        send_grid_pixels(4, 1'b0, -1);
        settle_block();
        program_grid(32'd7, 32'd3, 32'd9, 32'd1);
        send_grid_pixels(21, 1'b1, -1);
        settle_block();
    endtask

    // zero and oversized registers, upper write bits dropped
    task automatic test_register_extremes();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        // all zero: a one pixel frame per pixel
        program_grid(32'hFFFF_E000, 32'h0000_0000, 32'hFFFF_FFE0, 32'hAAAA_C000);
        verify_regs();
        send_grid_pixels(8, 1'b0, -1);
        settle_block();
        // widest image, column count above its maximum
        program_grid(32'h0000_1FFF, 32'd1, 32'd31, 32'h0000_1FFF);
        verify_regs();
        send_grid_pixels(600, 1'b1, 300);
        send_pixel(8'd255, 1'b1);
        settle_block();
        // tallest image, one pixel wide, one block per row
        program_grid(32'd1, 32'd4096, 32'd16, 32'd4096);
        rx_steady = 1'b1;
        send_grid_pixels(300, 1'b1, -1);
        settle_block();
        // same height clamped from above, widest image, one pixel row per block row
        program_grid(32'd4096, 32'h0000_1FFF, 32'd16, 32'd4096);
        rx_steady = 1'b0;
        send_grid_pixels(40, 1'b0, -1);
        settle_block();
    endtask

    task automatic program_random_grid();
        logic [31:0] vals [4];
        int          r, rot;
        r = $urandom_range(0, 19);
        vals[0] = (r == 0) ? 32'd0 : (r == 1) ? $urandom_range(17, 60) : $urandom_range(1, 16);
        vals[1] = $urandom_range(0, 9);
        r = $urandom_range(0, 19);
        vals[2] = (r < 2) ? 32'd0 : (r < 4) ? $urandom_range(17, 31) : $urandom_range(1, 16);
        r = $urandom_range(0, 19);
        vals[3] = (r < 2) ? 32'd0 : (r < 4) ? $urandom_range(11, 8191) : $urandom_range(1, 10);
        // junk in the unused upper bits
        if ($urandom_range(0, 7) == 0) begin
            vals[0] |= $urandom & 32'hFFFF_E000;
            vals[1] |= $urandom & 32'hFFFF_E000;
            vals[2] |= $urandom & 32'hFFFF_FFE0;
            vals[3] |= $urandom & 32'hFFFF_E000;
        end
        rot = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) write_reg(t_reg_idx'((k + rot) % 4), vals[(k + rot) % 4]);
        if ($urandom_range(0, 5) == 0) verify_regs();
    endtask

    // random grids, mostly whole frames, some restarts, cut frames and pauses
    task automatic test_random_grids();
        int start_count, npix, nframes, choice;
        bit aligned;
        start_count = pixels_sent;
        aligned     = 1'b0;
        while (pixels_sent - start_count < RANDOM_PIXELS) begin
            settle_block();
            if ($urandom_range(0, 9) != 0) begin
                program_random_grid();
                aligned = 1'b1;
            end
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            nframes   = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++) begin
                npix   = frame_pixels();
                choice = $urandom_range(0, 99);
                if (choice < 70) begin
                    send_grid_pixels(npix, !aligned || ($urandom_range(0, 1) == 1), -1);
                    aligned = 1'b1;
                end else if (choice < 82) begin
                    send_grid_pixels(npix, 1'b1, $urandom_range(0, npix - 1));
                    aligned = 1'b1;
                end else if (choice < 92) begin
                    send_grid_pixels($urandom_range(0, npix - 1), 1'b1, -1);
                    aligned = 1'b0;
                end else begin
                    send_grid_pixels($urandom_range(1, 4), 1'b0, -1);
                    aligned = 1'b0;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_grid_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // let the post-reset length pass run before the first transaction
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        test_reset_values();
        test_small_grid();
        test_whole_axis_blocks();
        test_register_extremes();
        test_random_grids();
        settle_block();

        if (err_count == 0 && pending_means.size() == 0) begin
            $display("tb_grid_block_mean OK");
        end else begin
            $display("tb_grid_block_mean NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/gbm_pkg.sv
sv/gbm_ram.sv
sv/gbm_div.sv
sv/grid_block_mean.sv
sv/gbm_checker.sv
verif/tb_grid_block_mean.sv
